@@ design/c8ic_pkg.sv @@
// Shared constants, state encoding and display command type of the CHIP-8 core.
`default_nettype none

package c8ic_pkg;

  localparam int DispWidth  = 64;
  localparam int DispHeight = 32;
  localparam int DispColAw  = 6;
  localparam int DispRowAw  = 5;
  localparam int RegCount   = 16;
  localparam int RegAw      = 4;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_EXEC  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [3:0] OP_SYS   = 4'h0;
  localparam logic [3:0] OP_JUMP  = 4'h1;
  localparam logic [3:0] OP_LOAD  = 4'h6;
  localparam logic [3:0] OP_ADD   = 4'h7;
  localparam logic [3:0] OP_INDEX = 4'hA;
  localparam logic [3:0] OP_DRAW  = 4'hD;

  localparam logic [15:0]      INSTR_CLS = 16'h00E0;
  localparam logic [RegAw-1:0] REG_FLAG  = 4'hF;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH0,
    S_FETCH1,
    S_DECODE,
    S_EXEC,
    S_CLRDISP,
    S_DRAWY,
    S_ROWRD,
    S_ROWWR,
    S_VFWR,
    S_PIXRD,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                 rd;
    logic                 clear;
    logic                 draw;
    logic [DispRowAw-1:0] row;
    logic [7:0]           sprite;
    logic [DispColAw-1:0] x0;
  } disp_cmd_t;

endpackage

`default_nettype wire

@@ design/c8ic_display.sv @@
// Display row store with the sprite shift, XOR write-back and collision detect.
`default_nettype none

module c8ic_display
  import c8ic_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire disp_cmd_t            cmd_i,
  output logic      [DispWidth-1:0] row_o,
  output logic                      hit_o
);

  logic [DispWidth-1:0] mem_q [DispHeight];
  logic [DispWidth-1:0] rd_q;
  logic [DispWidth-1:0] mask;

  // column x sits at bit (DispWidth-1-x); bits shifted past the right edge drop
  assign mask = {cmd_i.sprite, {(DispWidth-8){1'b0}}} >> cmd_i.x0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem_q[cmd_i.row] <= '0;
    end else if (cmd_i.draw) begin
      mem_q[cmd_i.row] <= rd_q ^ mask;
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[cmd_i.row];
    end
  end

  assign row_o = rd_q;
  assign hit_o = |(rd_q & mask);

endmodule

`default_nettype wire

@@ design/chip8_instruction_core_top.sv @@
// Top level of the reduced CHIP-8 core: sequencer, program memory and registers.
// Each item ends with its result loaded into the output register, where it then waits.
// One item at a time: the sequencer, the single program memory read port and the
// one-row display port carry each step in turn; the next item is taken once the result loads.
// After reset a clearing pass zeroes memory and display first.
`default_nettype none

module chip8_instruction_core_top
  import c8ic_pkg::*;
#(
  parameter int MEM_DEPTH = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [11:0] mem_addr_i,
  input  wire logic [7:0]  mem_data_i,
  input  wire logic [5:0]  pixel_x_i,
  input  wire logic [4:0]  pixel_y_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             status_o,
  output logic [15:0]      instruction_o,
  output logic [11:0]      pc_after_o,
  output logic             collision_o,
  output logic             pixel_value_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int MemAw = $clog2(MEM_DEPTH);

  state_e state_q, state_d;

  logic [11:0]          pc_q, pc_d;
  logic [11:0]          start_q, start_d;
  logic [11:0]          index_q, index_d;
  logic [15:0]          instr_q, instr_d;
  logic [DispColAw-1:0] px_q, px_d;
  logic [DispColAw-1:0] x0_q, x0_d;
  logic [DispRowAw-1:0] y0_q, y0_d;
  logic [DispRowAw-1:0] cnt_q, cnt_d;
  logic [DispRowAw-1:0] row_q, row_d;
  logic                 hit_q, hit_d;
  logic                 bad_q, bad_d;
  logic                 pix_q, pix_d;
  logic                 vf_q, vf_d;
  logic [MemAw-1:0]     clr_q, clr_d;
  logic                 out_valid_q, out_load;

  logic        in_accept, cfg_we;
  logic [DispRowAw:0] ysum;

  // program memory
  logic [7:0]  mem_q [MEM_DEPTH];
  logic [7:0]  mem_raw_q;
  logic        mem_oob_q;
  logic [7:0]  mem_rdata;
  logic        mem_we;
  logic [11:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_wdata;

  // byte registers
  logic [7:0]          vmem_q [RegCount];
  logic [RegCount-1:0] vvalid_q;
  logic [7:0]          vrd_q;
  logic                v_we, v_re;
  logic [RegAw-1:0]    v_waddr, v_raddr;
  logic [7:0]          v_wdata;

  disp_cmd_t            disp_cmd;
  logic [DispWidth-1:0] disp_row;
  logic                 disp_hit;

  c8ic_display u_display (
    .clk_i (clk_i),
    .cmd_i (disp_cmd),
    .row_o (disp_row),
    .hit_o (disp_hit)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_we     = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == 1'b0) ? {20'd0, start_q} : 32'd0;

  assign ysum      = {1'b0, y0_q} + {1'b0, cnt_q};
  assign mem_rdata = mem_oob_q ? 8'd0 : mem_raw_q;

  always_ff @(posedge clk_i) begin
    if (mem_we && ({1'b0, mem_waddr} < 13'(MEM_DEPTH))) begin
      mem_q[mem_waddr[MemAw-1:0]] <= mem_wdata;
    end
    mem_raw_q <= mem_q[mem_raddr[MemAw-1:0]];
    mem_oob_q <= ({1'b0, mem_raddr} >= 13'(MEM_DEPTH));
  end

  always_ff @(posedge clk_i) begin
    if (v_we) begin
      vmem_q[v_waddr] <= v_wdata;
    end
    if (v_re) begin
      vrd_q <= vvalid_q[v_raddr] ? vmem_q[v_raddr] : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vvalid_q <= '0;
    end else if (v_we) begin
      vvalid_q[v_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      pc_q        <= 12'd512;
      start_q     <= 12'd512;
      index_q     <= '0;
      vf_q        <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      start_q <= start_d;
      index_q <= index_d;
      vf_q    <= vf_d;
      clr_q   <= clr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    instr_q <= instr_d;
    px_q    <= px_d;
    x0_q    <= x0_d;
    y0_q    <= y0_d;
    cnt_q   <= cnt_d;
    row_q   <= row_d;
    hit_q   <= hit_d;
    bad_q   <= bad_d;
    pix_q   <= pix_d;
    if (out_load) begin
      status_o      <= bad_q;
      instruction_o <= instr_q;
      pc_after_o    <= pc_q;
      collision_o   <= vf_q;
      pixel_value_o <= pix_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d  = state_q;
    pc_d     = pc_q;
    start_d  = start_q;
    index_d  = index_q;
    instr_d  = instr_q;
    px_d     = px_q;
    x0_d     = x0_q;
    y0_d     = y0_q;
    cnt_d    = cnt_q;
    row_d    = row_q;
    hit_d    = hit_q;
    bad_d    = bad_q;
    pix_d    = pix_q;
    vf_d     = vf_q;
    clr_d    = clr_q;
    out_load = 1'b0;

    mem_we    = 1'b0;
    mem_waddr = mem_addr_i;
    mem_wdata = mem_data_i;
    mem_raddr = pc_q;

    v_we    = 1'b0;
    v_re    = 1'b0;
    v_waddr = instr_q[11:8];
    v_wdata = instr_q[7:0];
    v_raddr = instr_q[11:8];

    disp_cmd = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = 12'(clr_q);
        mem_wdata = 8'd0;
        if (clr_q[MemAw-1:DispRowAw] == '0) begin
          disp_cmd.clear = 1'b1;
          disp_cmd.row   = clr_q[DispRowAw-1:0];
        end
        if (clr_q == MemAw'(MEM_DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          instr_d = '0;
          bad_d   = 1'b0;
          pix_d   = 1'b0;
          unique case (req_type_i)
            REQ_WRITE: begin
              mem_we  = 1'b1;
              state_d = S_DONE;
            end
            REQ_EXEC: state_d = S_FETCH0;
            REQ_READ: begin
              disp_cmd.rd  = 1'b1;
              disp_cmd.row = pixel_y_i;
              px_d         = pixel_x_i;
              state_d      = S_PIXRD;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_FETCH0: begin
        mem_raddr = pc_q;
        state_d   = S_FETCH1;
      end
      S_FETCH1: begin
        mem_raddr = pc_q + 12'd1;
        instr_d   = {mem_rdata, instr_q[7:0]};
        state_d   = S_DECODE;
      end
      S_DECODE: begin
        instr_d = {instr_q[15:8], mem_rdata};
        pc_d    = pc_q + 12'd2;
        v_re    = 1'b1;
        v_raddr = instr_q[11:8];
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        unique case (instr_q[15:12])
          OP_SYS: begin
            if (instr_q == INSTR_CLS) begin
              cnt_d   = '0;
              state_d = S_CLRDISP;
            end else begin
              bad_d = 1'b1;
            end
          end
          OP_JUMP:  pc_d = instr_q[11:0];
          OP_LOAD:  v_we = 1'b1;
          OP_ADD: begin
            v_we    = 1'b1;
            v_wdata = vrd_q + instr_q[7:0];
          end
          OP_INDEX: index_d = instr_q[11:0];
          OP_DRAW: begin
            x0_d    = vrd_q[DispColAw-1:0];
            v_re    = 1'b1;
            v_raddr = instr_q[7:4];
            state_d = S_DRAWY;
          end
          default: bad_d = 1'b1;
        endcase
        if (v_we && (v_waddr == REG_FLAG)) begin
          vf_d = v_wdata[0];
        end
      end
      S_CLRDISP: begin
        disp_cmd.clear = 1'b1;
        disp_cmd.row   = cnt_q;
        if (cnt_q == DispRowAw'(DispHeight - 1)) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DRAWY: begin
        y0_d    = vrd_q[DispRowAw-1:0];
        cnt_d   = '0;
        hit_d   = 1'b0;
        state_d = S_ROWRD;
      end
      S_ROWRD: begin
        // stop at the sprite height or at the bottom edge
        if ((cnt_q == {1'b0, instr_q[3:0]}) || ysum[DispRowAw]) begin
          state_d = S_VFWR;
        end else begin
          mem_raddr    = index_q + 12'(cnt_q);
          disp_cmd.rd  = 1'b1;
          disp_cmd.row = ysum[DispRowAw-1:0];
          row_d        = ysum[DispRowAw-1:0];
          state_d      = S_ROWWR;
        end
      end
      S_ROWWR: begin
        disp_cmd.draw   = 1'b1;
        disp_cmd.row    = row_q;
        disp_cmd.sprite = mem_rdata;
        disp_cmd.x0     = x0_q;
        hit_d           = hit_q | disp_hit;
        cnt_d           = cnt_q + 1'b1;
        state_d         = S_ROWRD;
      end
      S_VFWR: begin
        v_we    = 1'b1;
        v_waddr = REG_FLAG;
        v_wdata = {7'd0, hit_q};
        vf_d    = hit_q;
        state_d = S_DONE;
      end
      S_PIXRD: begin
        pix_d   = disp_row[~px_q];
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we) begin
      start_d = pwdata[11:0];
      pc_d    = pwdata[11:0];
    end
  end

endmodule

`default_nettype wire

@@ test/c8ic_core_checker.sv @@
// Checker for the CHIP-8 core: predicts each result and compares it with the block's output.
`timescale 1ns / 1ps

module c8ic_core_checker
  import c8ic_pkg::*;
#(
  parameter int         MemDepth     = 4096,
  parameter logic [2:0] StartRegAddr = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  req_type_i,
  input  logic [11:0] mem_addr_i,
  input  logic [7:0]  mem_data_i,
  input  logic [5:0]  pixel_x_i,
  input  logic [4:0]  pixel_y_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        status_i,
  input  logic [15:0] instruction_i,
  input  logic [11:0] pc_after_i,
  input  logic        collision_i,
  input  logic        pixel_value_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          err_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic        status;
    logic [15:0] instruction;
    logic [11:0] pc_after;
    logic        collision;
    logic        pixel_value;
  } core_result_t;

  logic [7:0]   mem_q [0:4095];
  logic         disp_q [0:DispWidth*DispHeight-1];
  logic [7:0]   vreg [0:RegCount-1];
  logic [11:0]  index_reg;
  logic [11:0]  pc_reg;
  logic [11:0]  start_reg;
  core_result_t due_results [$];
  int           mismatches = 0;

  assign err_count_o = mismatches;

  function automatic logic [7:0] mem_rd(logic [11:0] addr);
    return (addr < MemDepth) ? mem_q[addr] : 8'h00;
  endfunction

  function automatic void clear_display();
    for (int c = 0; c < DispWidth * DispHeight; c++) disp_q[c] = 1'b0;
  endfunction

  // Start position is taken before VF is written; no wrap at the edges.
  function automatic void draw_sprite(logic [3:0] xr, logic [3:0] yr, logic [3:0] rows);
    int         x0;
    int         y0;
    int         dot;
    logic [7:0] line;
    logic       hit;
    x0  = int'(vreg[xr][5:0]);
    y0  = int'(vreg[yr][4:0]);
    hit = 1'b0;
    for (int r = 0; r < rows; r++) begin
      if (y0 + r >= DispHeight) break;
      line = mem_rd(index_reg + 12'(r));
      for (int c = 0; c < 8; c++) begin
        if (x0 + c >= DispWidth) break;
        if (line[7-c]) begin
          dot = (y0 + r) * DispWidth + x0 + c;
          if (disp_q[dot]) hit = 1'b1;
          disp_q[dot] = ~disp_q[dot];
        end
      end
    end
    vreg[REG_FLAG] = {7'b0, hit};
  endfunction

  function automatic core_result_t core_step(logic [1:0] kind, logic [11:0] addr,
                                             logic [7:0] data, logic [5:0] px,
                                             logic [4:0] py);
    core_result_t res;
    logic [15:0]  word;
    res = '0;
    case (kind)
      REQ_WRITE: begin
        if (addr < MemDepth) mem_q[addr] = data;
      end
      REQ_EXEC: begin
        word            = {mem_rd(pc_reg), mem_rd(pc_reg + 12'd1)};
        res.instruction = word;
        pc_reg          = pc_reg + 12'd2;
        case (word[15:12])
          OP_SYS: begin
            if (word == INSTR_CLS) clear_display();
            else res.status = 1'b1;
          end
          OP_JUMP:  pc_reg = word[11:0];
          OP_LOAD:  vreg[word[11:8]] = word[7:0];
          OP_ADD:   vreg[word[11:8]] = vreg[word[11:8]] + word[7:0];
          OP_INDEX: index_reg = word[11:0];
          OP_DRAW:  draw_sprite(word[11:8], word[7:4], word[3:0]);
          default:  res.status = 1'b1;
        endcase
      end
      REQ_READ: res.pixel_value = disp_q[int'(py) * DispWidth + int'(px)];
      default: ;
    endcase
    res.pc_after  = pc_reg;
    res.collision = vreg[REG_FLAG][0];
    return res;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    core_result_t want;
    if (!rst_ni) begin
      for (int a = 0; a < 4096; a++) mem_q[a] = 8'h00;
      for (int r = 0; r < RegCount; r++) vreg[r] = 8'h00;
      clear_display();
      index_reg = '0;
      start_reg = 12'h200;
      pc_reg    = start_reg;
      due_results.delete();
      pending_o <= 0;
    end else begin
      // a start address write loads the program counter at once
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == StartRegAddr) begin
        start_reg = pwdata_i[11:0];
        pc_reg    = start_reg;
      end
      // pop before push: no item can come out in the cycle it goes in
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("result with no item waiting: instruction %0h pc %0h",
                 instruction_i, pc_after_i);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("status", 16'(want.status), 16'(status_i));
          check_field("instruction", want.instruction, instruction_i);
          check_field("pc_after", 16'(want.pc_after), 16'(pc_after_i));
          check_field("collision", 16'(want.collision), 16'(collision_i));
          check_field("pixel_value", 16'(want.pixel_value), 16'(pixel_value_i));
        end
      end
      if (in_valid_i && !in_stall_i)
        due_results.push_back(core_step(req_type_i, mem_addr_i, mem_data_i,
                                        pixel_x_i, pixel_y_i));
      pending_o <= due_results.size();
    end
  end

endmodule

@@ test/chip8_instruction_core_top_tb.sv @@
// Testbench top for the CHIP-8 core: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module chip8_instruction_core_top_tb;
  import c8ic_pkg::*;

  localparam logic [1:0] REQ_NOP        = 2'd3;
  localparam logic [2:0] START_REG_ADDR = 3'd0;
  localparam int         QUIET_LIMIT    = 20000;
  localparam int         PHASE_ITEMS    = 290;
  localparam int         TAIL_CYCLES    = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  req_type = '0;
  logic [11:0] mem_addr = '0;
  logic [7:0]  mem_data = '0;
  logic [5:0]  pixel_x = '0;
  logic [4:0]  pixel_y = '0;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;

  logic        in_stall;
  logic        out_valid;
  logic        status;
  logic [15:0] instruction;
  logic [11:0] pc_after;
  logic        collision;
  logic        pixel_value;
  logic [31:0] prdata;
  logic        pready;

  int          chk_errors;
  int          pending;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  logic        calm = 1'b0;
  logic [11:0] code_pc = 12'h200;

  always #5 clk_i = ~clk_i;

  chip8_instruction_core_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .req_type_i    (req_type),
    .mem_addr_i    (mem_addr),
    .mem_data_i    (mem_data),
    .pixel_x_i     (pixel_x),
    .pixel_y_i     (pixel_y),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .instruction_o (instruction),
    .pc_after_o    (pc_after),
    .collision_o   (collision),
    .pixel_value_o (pixel_value),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  c8ic_core_checker #(
    .StartRegAddr (START_REG_ADDR)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .req_type_i    (req_type),
    .mem_addr_i    (mem_addr),
    .mem_data_i    (mem_data),
    .pixel_x_i     (pixel_x),
    .pixel_y_i     (pixel_y),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .status_i      (status),
    .instruction_i (instruction),
    .pc_after_i    (pc_after),
    .collision_i   (collision),
    .pixel_value_i (pixel_value),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .err_count_o   (chk_errors),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    out_stall <= !calm && ($urandom_range(99) < 34);
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [11:0] addr,
                           input logic [7:0] data, input logic [5:0] px,
                           input logic [4:0] py);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    req_type <= kind;
    mem_addr <= addr;
    mem_data <= data;
    pixel_x  <= px;
    pixel_y  <= py;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic write_byte(input logic [11:0] addr, input logic [7:0] data);
    send_item(REQ_WRITE, addr, data, 6'($urandom), 5'($urandom));
  endtask

  task automatic read_pixel(input logic [5:0] px, input logic [4:0] py);
    send_item(REQ_READ, 12'($urandom), 8'($urandom), px, py);
  endtask

  // place the word at the program counter, then execute it
  task automatic run_word(input logic [15:0] word);
    write_byte(code_pc, word[15:8]);
    write_byte(code_pc + 12'd1, word[7:0]);
    send_item(REQ_EXEC, 12'($urandom), 8'($urandom), 6'($urandom), 5'($urandom));
    code_pc = (word[15:12] == OP_JUMP) ? word[11:0] : code_pc + 12'd2;
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_start(input logic [11:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= START_REG_ADDR;
    pwdata  <= {20'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    code_pc = value;
  endtask

  task automatic random_burst();
    int          pick;
    logic [11:0] base;
    logic [3:0]  rows;
    logic [3:0]  xr;
    logic [3:0]  yr;
    logic [7:0]  xv;
    logic [7:0]  yv;
    logic [7:0]  lx;
    logic [3:0]  grp;
    logic [11:0] rest;
    logic [15:0] word;
    pick = $urandom_range(99);
    if (pick < 30) begin
      // sprite scene: data, position, index, draw, maybe redraw, then look at it
      base = 12'($urandom);
      rows = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 4));
      for (int k = 0; k < rows; k++)
        write_byte(base + 12'(k), ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom));
      xr = 4'($urandom);
      yr = 4'($urandom);
      xv = ($urandom_range(2) == 0) ? 8'($urandom_range(56, 63) + 64 * $urandom_range(3))
                                    : 8'($urandom);
      yv = ($urandom_range(2) == 0) ? 8'($urandom_range(24, 31) + 32 * $urandom_range(7))
                                    : 8'($urandom);
      run_word({OP_LOAD, xr, xv});
      run_word({OP_LOAD, yr, yv});
      run_word({OP_INDEX, base});
      run_word({OP_DRAW, xr, yr, rows});
      if ($urandom_range(2) == 0) run_word({OP_DRAW, xr, yr, rows});
      lx = (xr == yr) ? yv : xv;
      repeat ($urandom_range(1, 3))
        read_pixel(6'(lx + $urandom_range(7)), 5'(yv + $urandom_range(rows)));
    end else if (pick < 60) begin
      rest = 12'($urandom);
      case ($urandom_range(9))
        0:       word = INSTR_CLS;
        1:       word = {OP_JUMP, rest};
        2, 3:    word = {OP_LOAD, rest};
        4, 5:    word = {OP_ADD, rest};
        6:       word = {OP_INDEX, rest};
        default: word = {OP_DRAW, rest};
      endcase
      run_word(word);
    end else if (pick < 70) begin
      do grp = 4'($urandom_range(15));
      while (grp == OP_JUMP || grp == OP_LOAD || grp == OP_ADD || grp == OP_INDEX ||
             grp == OP_DRAW);
      rest = 12'($urandom);
      if (grp == OP_SYS && rest == INSTR_CLS[11:0]) rest = rest + 12'd1;
      run_word({grp, rest});
    end else if (pick < 85) begin
      read_pixel(6'($urandom), 5'($urandom));
    end else if (pick < 95) begin
      write_byte(12'($urandom), 8'($urandom));
    end else begin
      send_item(REQ_NOP, 12'($urandom), 8'($urandom), 6'($urandom), 5'($urandom));
    end
  endtask

  initial begin
    int          phase_end;
    logic [11:0] start_value;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: sprite from the top of memory, clipped at the corner
    write_byte(12'hFFF, 8'hFF);
    send_item(REQ_NOP, 12'h000, 8'h00, 6'h00, 5'h00);
    run_word({OP_LOAD, 4'h0, 8'h3E});
    run_word({OP_LOAD, 4'h1, 8'h1F});
    run_word({OP_INDEX, 12'hFFF});
    run_word({OP_DRAW, 4'h0, 4'h1, 4'h2});
    read_pixel(6'd63, 5'd31);
    run_word({OP_DRAW, 4'h0, 4'h1, 4'h2});
    run_word({OP_DRAW, 4'h0, 4'h1, 4'h0});
    run_word({OP_ADD, REG_FLAG, 8'hFF});
    run_word(INSTR_CLS);
    run_word({OP_SYS, 12'h123});
    run_word({OP_JUMP, 12'hFFE});

    for (int phase = 0; phase < 4; phase++) begin
      in_valid <= 1'b0;
      drain();
      case (phase)
        0:       start_value = 12'h000;
        1:       start_value = 12'hFFF;
        2:       start_value = 12'($urandom);
        default: start_value = 12'h200;
      endcase
      write_start(start_value);
      calm <= (phase == 1);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_burst();
    end

    in_valid <= 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (chk_errors == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
design/c8ic_pkg.sv
design/c8ic_display.sv
design/chip8_instruction_core_top.sv
test/c8ic_core_checker.sv
test/chip8_instruction_core_top_tb.sv
